/* rtl/rmeu_pkg.sv */
// rmeu_pkg: shared types and codes of the register machine execute unit
// depends on nothing; imported by the shared unit, the top level and the testbench
package rmeu_pkg;

  // function codes
  typedef enum logic [3:0] {
    F_LOAD  = 4'd0,
    F_ADD   = 4'd1,
    F_SUB   = 4'd2,
    F_MUL   = 4'd3,
    F_DIV   = 4'd4,
    F_POW   = 4'd5,
    F_AND   = 4'd6,
    F_OR    = 4'd7,
    F_XOR   = 4'd8,
    F_NOT   = 4'd9,
    F_STORE = 4'd10
  } func_t;

  // operand source codes; the fourth code reads memory as well
  typedef enum logic [1:0] {
    MODE_IMM = 2'd0,
    MODE_REG = 2'd1,
    MODE_MEM = 2'd2,
    MODE_MEM_ALT = 2'd3
  } mode_t;

  // guard codes
  typedef enum logic [2:0] {
    G_ALWAYS = 3'd0,
    G_EQ     = 3'd1,
    G_NE     = 3'd2,
    G_LT     = 3'd3,
    G_GT     = 3'd4,
    G_LE     = 3'd5,
    G_GE     = 3'd6,
    G_NEVER  = 3'd7
  } guard_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_REG  = 2'd1,
    ERR_DIV  = 2'd2,
    ERR_ADDR = 2'd3
  } err_t;

  // operand slots in fetch order
  typedef enum logic [1:0] {
    OPS_C = 2'd0,
    OPS_D = 2'd1,
    OPS_A = 2'd2,
    OPS_B = 2'd3
  } opsel_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MEMRD,
    ST_GUARD,
    ST_EXEC,
    ST_MDWAIT,
    ST_POW,
    ST_POWMUL,
    ST_POWSQ,
    ST_WRITE,
    ST_DONE
  } state_t;

  // shared multiply / divide unit
  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

  // one input beat as latched by the sequencer
  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] dest;
    logic [1:0]  a_mode;
    logic [31:0] a_value;
    logic [1:0]  b_mode;
    logic [31:0] b_value;
    logic [2:0]  guard;
    logic [1:0]  c_mode;
    logic [31:0] c_value;
    logic [1:0]  d_mode;
    logic [31:0] d_value;
  } item_t;

endpackage

/* rtl/rmeu_if.sv */
// rmeu_if: valid/ready channel interfaces for instruction and result beats
// no dependencies
interface rmeu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [15:0] dest;
  logic [1:0]  a_mode;
  logic signed [31:0] a_value;
  logic [1:0]  b_mode;
  logic signed [31:0] b_value;
  logic [2:0]  guard;
  logic [1:0]  c_mode;
  logic signed [31:0] c_value;
  logic [1:0]  d_mode;
  logic signed [31:0] d_value;

  modport source (output valid, func, dest, a_mode, a_value, b_mode, b_value, guard,
                  c_mode, c_value, d_mode, d_value, input ready);
  modport sink   (input valid, func, dest, a_mode, a_value, b_mode, b_value, guard,
                  c_mode, c_value, d_mode, d_value, output ready);
endinterface

interface rmeu_out_if;
  logic        valid;
  logic        ready;
  logic        executed;
  logic signed [31:0] written_value;
  logic [1:0]  error;

  modport source (output valid, executed, written_value, error, input ready);
  modport sink   (input valid, executed, written_value, error, output ready);
endinterface

/* rtl/rmeu_muldiv.sv */
// rmeu_muldiv: shared bit-serial multiplier and restoring signed divider
// depends on rmeu_pkg; one bit per cycle
module rmeu_muldiv import rmeu_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  md_req_t      req,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output md_stat_t     stat,
  output logic [W-1:0] result
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  md_op_t        op_r, op_nxt;
  logic          neg_r, neg_nxt;
  logic [W:0]    acc_r, acc_nxt;
  logic [W-1:0]  opa_r, opa_nxt;
  logic [W-1:0]  opb_r, opb_nxt;

  // start, one step per cycle, finish
  always_comb begin
    logic [W:0]   rem_sh;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    opa_nxt  = opa_r;
    opb_nxt  = opb_r;
    rem_sh   = {acc_r[W-1:0], opa_r[W-1]};
    ma       = a[W-1] ? (~a + 1'b1) : a;
    mb       = b[W-1] ? (~b + 1'b1) : b;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      op_nxt   = req.op;
      acc_nxt  = '0;
      if (req.op == MD_DIV) begin
        opa_nxt = ma;
        opb_nxt = mb;
        neg_nxt = a[W-1] ^ b[W-1];
      end else begin
        opa_nxt = a;
        opb_nxt = b;
        neg_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (op_r == MD_DIV) begin
        if (rem_sh >= {1'b0, opb_r}) begin
          acc_nxt = rem_sh - {1'b0, opb_r};
          opa_nxt = {opa_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh;
          opa_nxt = {opa_r[W-2:0], 1'b0};
        end
      end else begin
        if (opb_r[0]) begin
          acc_nxt = {1'b0, acc_r[W-1:0] + opa_r};
        end
        opa_nxt = {opa_r[W-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[W-1:1]};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
  end

  // result holds once done until the next start
  always_comb begin
    if (op_r == MD_DIV) begin
      result = neg_r ? (~opa_r + 1'b1) : opa_r;
    end else begin
      result = acc_r[W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/register_machine_execute_unit_top.sv */
// register_machine_execute_unit_top: sequencer, register file and data memory
// depends on rmeu_pkg, rmeu_if and rmeu_muldiv
//
// Executes one decoded instruction per input beat and returns one result beat.
// After reset a clearing pass zeroes the data memory, one word a cycle; no
// instruction is taken meanwhile. An instruction then passes through accept,
// operand fetch, where a memory operand adds a read state (the data memory read
// is registered), guard, execute, write and result hand-over. Multiply and
// divide run in the shared bit-serial unit; power with a non-negative exponent
// steps through ST_POW once per exponent bit up to the highest set one and once
// more, and runs each multiply of square-and-multiply, up to two per exponent
// bit, in the shared unit. The hand-over repeats while the previous result still
// sits unaccepted in the output register. A result waits in the output register
// while the next beat is taken.
module register_machine_execute_unit_top import rmeu_pkg::*; #(
  parameter int NUM_REGS   = 10,
  parameter int MEM_WORDS  = 65536,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  rmeu_in_if.sink     in_ch,
  rmeu_out_if.source  out_ch
);

  localparam int W  = DATA_WIDTH;
  localparam int RW = $clog2(NUM_REGS);
  localparam int AW = $clog2(MEM_WORDS);

  // immediate: sign-extend the 32-bit field, then cut to the data width
  function automatic logic [W-1:0] sext_imm(input logic [31:0] raw);
    logic [63:0] t;
    t = {{32{raw[31]}}, raw};
    return t[W-1:0];
  endfunction

  // low 32 bits of a data word, zero-extended when narrower
  function automatic logic [31:0] low32(input logic [W-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[31:0];
  endfunction

  state_t        state_r, state_nxt;
  opsel_t        opsel_r, opsel_nxt;
  item_t         item_r, item_nxt;
  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [W-1:0]  pr_r, pr_nxt, base_r, base_nxt, ex_r, ex_nxt;
  logic [W-1:0]  res_r, res_nxt;
  err_t          err_r, err_nxt;
  logic          exec_r, exec_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_exec_r, out_exec_nxt;
  logic [31:0]   out_val_r, out_val_nxt;
  err_t          out_err_r, out_err_nxt;

  logic [W-1:0]  rf_r [NUM_REGS];
  logic          rf_we;
  logic [RW-1:0] rf_wa;

  logic [W-1:0]  mem [MEM_WORDS];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [W-1:0]  mem_wd, mem_rd_r;

  md_req_t       md_req;
  md_stat_t      md_stat;
  logic [W-1:0]  md_a, md_b, md_res;

  rmeu_muldiv #(.W(W)) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .a      (md_a),
    .b      (md_b),
    .stat   (md_stat),
    .result (md_res)
  );

  // sequencer
  always_comb begin
    logic [1:0]   mode;
    logic [31:0]  raw;
    logic         got;
    logic [W-1:0] got_val;
    logic         hold;
    logic         two;
    state_nxt     = state_r;
    opsel_nxt     = opsel_r;
    item_nxt      = item_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    pr_nxt = pr_r; base_nxt = base_r; ex_nxt = ex_r;
    res_nxt = res_r; err_nxt = err_r; exec_nxt = exec_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_exec_nxt  = out_exec_r;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    rf_we  = 1'b0;
    rf_wa  = item_r.dest[RW-1:0];
    mem_we = 1'b0;
    mem_wa = item_r.dest[AW-1:0];
    mem_wd = res_r;
    mem_ra = '0;
    md_req = '{start: 1'b0, op: MD_MUL};
    md_a   = a_r;
    md_b   = b_r;
    in_ch.ready = 1'b0;
    got     = 1'b0;
    got_val = '0;
    hold    = 1'b0;
    two     = !(item_r.func == F_LOAD || item_r.func == F_NOT || item_r.func == F_STORE);

    unique case (opsel_r)
      OPS_C:   begin mode = item_r.c_mode; raw = item_r.c_value; end
      OPS_D:   begin mode = item_r.d_mode; raw = item_r.d_value; end
      OPS_A:   begin mode = item_r.a_mode; raw = item_r.a_value; end
      default: begin mode = item_r.b_mode; raw = item_r.b_value; end
    endcase

    // output slot drains independently of the sequencer
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          item_nxt = '{func: in_ch.func, dest: in_ch.dest,
                       a_mode: in_ch.a_mode, a_value: in_ch.a_value,
                       b_mode: in_ch.b_mode, b_value: in_ch.b_value,
                       guard: in_ch.guard,
                       c_mode: in_ch.c_mode, c_value: in_ch.c_value,
                       d_mode: in_ch.d_mode, d_value: in_ch.d_value};
          err_nxt  = ERR_NONE;
          exec_nxt = 1'b0;
          res_nxt  = '0;
          opsel_nxt = OPS_C;
          state_nxt = (in_ch.guard == G_ALWAYS) ? ST_GUARD : ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (mode == MODE_IMM) begin
          got     = 1'b1;
          got_val = sext_imm(raw);
        end else if (mode == MODE_REG) begin
          if (raw >= 32'(NUM_REGS)) begin
            err_nxt   = ERR_REG;
            state_nxt = ST_DONE;
          end else begin
            got     = 1'b1;
            got_val = rf_r[raw[RW-1:0]];
          end
        end else begin
          if (raw >= 32'(MEM_WORDS)) begin
            err_nxt   = ERR_ADDR;
            state_nxt = ST_DONE;
          end else begin
            mem_ra    = raw[AW-1:0];
            state_nxt = ST_MEMRD;
          end
        end
      end
      ST_MEMRD: begin
        got     = 1'b1;
        got_val = mem_rd_r;
      end
      ST_GUARD: begin
        unique case (item_r.guard)
          G_ALWAYS: hold = 1'b1;
          G_EQ:     hold = (c_r == d_r);
          G_NE:     hold = (c_r != d_r);
          G_LT:     hold = ($signed(c_r) < $signed(d_r));
          G_GT:     hold = ($signed(d_r) < $signed(c_r));
          G_LE:     hold = !($signed(d_r) < $signed(c_r));
          G_GE:     hold = !($signed(c_r) < $signed(d_r));
          default:  hold = 1'b0;
        endcase
        if (!hold || item_r.func > F_STORE) begin
          state_nxt = ST_DONE;
        end else if (item_r.func == F_STORE && 32'(item_r.dest) >= 32'(MEM_WORDS)) begin
          err_nxt   = ERR_ADDR;
          state_nxt = ST_DONE;
        end else if (item_r.func != F_STORE && 32'(item_r.dest) >= 32'(NUM_REGS)) begin
          err_nxt   = ERR_REG;
          state_nxt = ST_DONE;
        end else begin
          opsel_nxt = OPS_A;
          state_nxt = ST_FETCH;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_WRITE;
        unique case (item_r.func)
          F_LOAD, F_STORE: res_nxt = a_r;
          F_ADD: res_nxt = a_r + b_r;
          F_SUB: res_nxt = a_r - b_r;
          F_AND: res_nxt = a_r & b_r;
          F_OR:  res_nxt = a_r | b_r;
          F_XOR: res_nxt = a_r ^ b_r;
          F_NOT: res_nxt = ~a_r;
          F_MUL: begin
            md_req    = '{start: 1'b1, op: MD_MUL};
            state_nxt = ST_MDWAIT;
          end
          F_DIV: begin
            if (b_r == '0) begin
              err_nxt   = ERR_DIV;
              state_nxt = ST_DONE;
            end else begin
              md_req    = '{start: 1'b1, op: MD_DIV};
              state_nxt = ST_MDWAIT;
            end
          end
          default: begin
            // power; a negative exponent only keeps a base of one or minus one
            if (b_r[W-1]) begin
              if (a_r == W'(1)) begin
                res_nxt = W'(1);
              end else if (a_r == '1) begin
                res_nxt = b_r[0] ? '1 : W'(1);
              end else begin
                res_nxt = '0;
              end
            end else begin
              pr_nxt    = W'(1);
              base_nxt  = a_r;
              ex_nxt    = b_r;
              state_nxt = ST_POW;
            end
          end
        endcase
      end
      ST_MDWAIT: begin
        if (md_stat.done) begin
          res_nxt   = md_res;
          state_nxt = ST_WRITE;
        end
      end
      ST_POW: begin
        md_a = pr_r;
        md_b = base_r;
        if (ex_r == '0) begin
          res_nxt   = pr_r;
          state_nxt = ST_WRITE;
        end else if (ex_r[0]) begin
          md_req    = '{start: 1'b1, op: MD_MUL};
          state_nxt = ST_POWMUL;
        end else begin
          md_a      = base_r;
          md_req    = '{start: 1'b1, op: MD_MUL};
          state_nxt = ST_POWSQ;
        end
      end
      ST_POWMUL: begin
        md_a = base_r;
        md_b = base_r;
        if (md_stat.done) begin
          pr_nxt    = md_res;
          md_req    = '{start: 1'b1, op: MD_MUL};
          state_nxt = ST_POWSQ;
        end
      end
      ST_POWSQ: begin
        if (md_stat.done) begin
          base_nxt  = md_res;
          ex_nxt    = {1'b0, ex_r[W-1:1]};
          state_nxt = ST_POW;
        end
      end
      ST_WRITE: begin
        if (item_r.func == F_STORE) begin
          mem_we = 1'b1;
        end else begin
          rf_we = 1'b1;
        end
        mem_wd    = res_r;
        exec_nxt  = 1'b1;
        state_nxt = ST_DONE;
      end
      default: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_exec_nxt  = exec_r;
          out_val_nxt   = exec_r ? low32(res_r) : 32'd0;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
    endcase

    // store the fetched operand and move on
    if (got) begin
      state_nxt = ST_FETCH;
      unique case (opsel_r)
        OPS_C: begin
          c_nxt     = got_val;
          opsel_nxt = OPS_D;
        end
        OPS_D: begin
          d_nxt     = got_val;
          state_nxt = ST_GUARD;
        end
        OPS_A: begin
          a_nxt = got_val;
          if (two) begin
            opsel_nxt = OPS_B;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
        default: begin
          b_nxt     = got_val;
          state_nxt = ST_EXEC;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      opsel_r     <= OPS_C;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      err_r       <= ERR_NONE;
      exec_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      opsel_r     <= opsel_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
      exec_r      <= exec_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    pr_r       <= pr_nxt;
    base_r     <= base_nxt;
    ex_r       <= ex_nxt;
    res_r      <= res_nxt;
    out_exec_r <= out_exec_nxt;
    out_val_r  <= out_val_nxt;
    out_err_r  <= out_err_nxt;
  end

  // register file, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
    end else if (rf_we) begin
      rf_r[rf_wa] <= res_r;
    end
  end

  // data memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.executed      = out_exec_r;
  assign out_ch.written_value = out_val_r;
  assign out_ch.error         = out_err_r;

  // an executed beat never carries an error
  a_exec_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_exec_r |-> out_err_r == ERR_NONE)
    else $error("executed result with error code");

  // nothing written means a zero value
  a_noexec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_exec_r |-> out_val_r == 32'd0)
    else $error("non-executed result with nonzero value");

  // no beat taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ch.ready)
    else $error("input ready during memory clear");

  // shared unit is quiet whenever the sequencer is idle
  a_idle_md: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !md_stat.busy)
    else $error("shared unit busy while idle");

  // a register or memory write is always followed by the result hand-over
  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |=> state_r == ST_DONE && exec_r)
    else $error("write not followed by result");

endmodule

/* tb/register_machine_execute_unit_top_tb.sv */
// register_machine_execute_unit_top_tb: directed and random checks of the execute unit
// depends on rmeu_pkg, rmeu_if and the register_machine_execute_unit_top rtl
`timescale 1ns / 100ps

module register_machine_execute_unit_top_tb import rmeu_pkg::*; ();

  localparam int NREGS = 10;
  localparam int NWORDS = 65536;
  localparam int DRAIN_CYCLES = 2000;
  localparam int STALL_LIMIT = 400000;

  typedef struct {
    logic        executed;
    logic [31:0] written_value;
    err_t        error;
  } outcome_t;

  // one directed row; check_typed selects the typed-in outcome over the predictor
  typedef struct {
    item_t    instr;
    bit       check_typed;
    outcome_t typed;
  } vector_t;

  logic clk;
  logic rst_n;

  rmeu_in_if  in_ch ();
  rmeu_out_if out_ch ();

  register_machine_execute_unit_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic [31:0] shadow_regs [NREGS];
  logic [31:0] shadow_mem [int];

  outcome_t pending_outcomes [$];
  int mismatch_count;
  int beats_sent;
  int beats_seen;
  int executed_seen;
  int error_seen;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit timed_out;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // operand fetch: returns error code, value in val
  function automatic err_t fetch_operand(logic [1:0] mode, logic [31:0] raw,
                                         output logic [31:0] val);
    val = '0;
    if (mode == MODE_IMM) begin
      val = raw;
      return ERR_NONE;
    end
    if (mode == MODE_REG) begin
      if (raw >= NREGS) return ERR_REG;
      val = shadow_regs[raw];
      return ERR_NONE;
    end
    if (raw >= NWORDS) return ERR_ADDR;
    val = shadow_mem.exists(raw) ? shadow_mem[raw] : 32'd0;
    return ERR_NONE;
  endfunction

  function automatic logic [31:0] signed_quotient(logic [31:0] n, logic [31:0] m);
    logic [31:0] mn;
    logic [31:0] mm;
    logic [31:0] q;
    mn = n[31] ? -n : n;
    mm = m[31] ? -m : m;
    q = mn / mm;
    return (n[31] != m[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] int_power(logic [31:0] base, logic [31:0] ex);
    logic [31:0] r;
    r = 32'd1;
    if (ex[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hffff_ffff) return ex[0] ? 32'hffff_ffff : 32'd1;
      return 32'd0;
    end
    while (ex != 0) begin
      if (ex[0]) r = r * base;
      base = base * base;
      ex = ex >> 1;
    end
    return r;
  endfunction

  // execute one instruction on the shadow state
  function automatic outcome_t execute_instr(item_t it);
    outcome_t o;
    logic [31:0] a, b, c, d, res;
    err_t e;
    bit holds;
    bit two_ops;
    a = '0; b = '0; c = '0; d = '0; res = '0;
    o.executed = 1'b0;
    o.written_value = '0;
    o.error = ERR_NONE;
    holds = 1'b1;
    if (it.guard != G_ALWAYS) begin
      e = fetch_operand(it.c_mode, it.c_value, c);
      if (e == ERR_NONE) e = fetch_operand(it.d_mode, it.d_value, d);
      if (e != ERR_NONE) begin
        o.error = e;
        return o;
      end
      case (guard_t'(it.guard))
        G_EQ: holds = (c == d);
        G_NE: holds = (c != d);
        G_LT: holds = ($signed(c) < $signed(d));
        G_GT: holds = ($signed(c) > $signed(d));
        G_LE: holds = ($signed(c) <= $signed(d));
        G_GE: holds = ($signed(c) >= $signed(d));
        default: holds = 1'b0;
      endcase
    end
    if (!holds || it.func > F_STORE) return o;
    if (it.func == F_STORE) e = (it.dest >= NWORDS) ? ERR_ADDR : ERR_NONE;
    else e = (it.dest >= NREGS) ? ERR_REG : ERR_NONE;
    if (e == ERR_NONE) e = fetch_operand(it.a_mode, it.a_value, a);
    two_ops = !(it.func == F_LOAD || it.func == F_NOT || it.func == F_STORE);
    if (e == ERR_NONE && two_ops) e = fetch_operand(it.b_mode, it.b_value, b);
    if (e == ERR_NONE && it.func == F_DIV && b == 0) e = ERR_DIV;
    if (e != ERR_NONE) begin
      o.error = e;
      return o;
    end
    case (func_t'(it.func))
      F_ADD: res = a + b;
      F_SUB: res = a - b;
      F_MUL: res = a * b;
      F_DIV: res = signed_quotient(a, b);
      F_POW: res = int_power(a, b);
      F_AND: res = a & b;
      F_OR:  res = a | b;
      F_XOR: res = a ^ b;
      F_NOT: res = ~a;
      default: res = a;
    endcase
    if (it.func == F_STORE) shadow_mem[it.dest] = res;
    else shadow_regs[it.dest] = res;
    o.executed = 1'b1;
    o.written_value = res;
    return o;
  endfunction

  function automatic item_t blank_instr();
    item_t it;
    it = '0;
    return it;
  endfunction

  function automatic item_t make_instr(func_t f, logic [15:0] dst, mode_t am, logic [31:0] av,
                                       mode_t bm, logic [31:0] bv);
    item_t it;
    it = blank_instr();
    it.func = f; it.dest = dst;
    it.a_mode = am; it.a_value = av;
    it.b_mode = bm; it.b_value = bv;
    return it;
  endfunction

  function automatic outcome_t make_outcome(logic x, logic [31:0] v, err_t e);
    outcome_t o;
    o.executed = x; o.written_value = v; o.error = e;
    return o;
  endfunction

  // operand source biased toward legal registers and a small address window
  function automatic void pick_operand(output logic [1:0] mode, output logic [31:0] val);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      mode = MODE_IMM;
      case ($urandom_range(0, 3))
        0: val = $urandom_range(0, 9);
        1: val = -$urandom_range(0, 9);
        2: val = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0};
        default: val = $urandom;
      endcase
    end else if (sel < 75) begin
      mode = MODE_REG;
      val = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, NREGS - 1);
    end else begin
      mode = ($urandom_range(0, 3) == 0) ? MODE_MEM_ALT : MODE_MEM;
      case ($urandom_range(0, 9))
        0: val = $urandom;
        1: val = $urandom_range(0, 65535);
        default: val = $urandom_range(0, 15);
      endcase
    end
  endfunction

  function automatic item_t random_instr();
    item_t it;
    logic [1:0] m;
    logic [31:0] v;
    it = blank_instr();
    it.func = 4'(($urandom_range(0, 29) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 10));
    if (it.func == F_STORE)
      it.dest = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15));
    else
      it.dest = 16'(($urandom_range(0, 14) == 0) ? $urandom : $urandom_range(0, NREGS - 1));
    pick_operand(m, v); it.a_mode = m; it.a_value = v;
    pick_operand(m, v); it.b_mode = m; it.b_value = v;
    // keep power exponents mostly small so runs stay short
    if (it.func == F_POW && $urandom_range(0, 3) != 0) begin
      it.b_mode = MODE_IMM;
      it.b_value = $urandom_range(0, 1) ? $urandom_range(0, 12) : -$urandom_range(1, 3);
    end
    it.guard = ($urandom_range(0, 1) == 0) ? G_ALWAYS : 3'($urandom_range(1, 7));
    pick_operand(m, v); it.c_mode = m; it.c_value = v;
    pick_operand(m, v); it.d_mode = m; it.d_value = v;
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (out_ch.executed) executed_seen++;
      if (out_ch.error != ERR_NONE) error_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: executed %0b value %h error %0d",
                   out_ch.executed, out_ch.written_value, out_ch.error);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_ch.executed !== want.executed || out_ch.written_value !== want.written_value ||
            out_ch.error !== want.error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d mismatch: expected %0b/%h/%0d got %0b/%h/%0d",
                     beats_seen, want.executed, want.written_value, want.error,
                     out_ch.executed, out_ch.written_value, out_ch.error);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("register_machine_execute_unit_top_tb: done, errors");
      $finish;
    end
  end

  // send one instruction beat; the expected outcome is queued at acceptance
  task automatic send_beat(item_t it, bit use_typed, outcome_t typed);
    outcome_t o;
    while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.func    <= it.func;    in_ch.dest    <= it.dest;
    in_ch.a_mode  <= it.a_mode;  in_ch.a_value <= it.a_value;
    in_ch.b_mode  <= it.b_mode;  in_ch.b_value <= it.b_value;
    in_ch.guard   <= it.guard;
    in_ch.c_mode  <= it.c_mode;  in_ch.c_value <= it.c_value;
    in_ch.d_mode  <= it.d_mode;  in_ch.d_value <= it.d_value;
    do @(posedge clk); while (!in_ch.ready);
    o = execute_instr(it);
    pending_outcomes.push_back(use_typed ? typed : o);
    beats_sent++;
    in_ch.valid <= 1'b0;
    // the unit is busy right after a beat, so dropping valid here costs nothing
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  initial begin
    vector_t vectors [$];
    vector_t v;
    item_t it;
    outcome_t none;
    int phase;
    none = make_outcome(1'b0, 32'd0, ERR_NONE);
    mismatch_count = 0; beats_sent = 0; beats_seen = 0;
    executed_seen = 0; error_seen = 0; idle_cycles = 0; timed_out = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= '0; in_ch.dest <= '0; in_ch.guard <= '0;
    in_ch.a_mode <= '0; in_ch.a_value <= '0; in_ch.b_mode <= '0; in_ch.b_value <= '0;
    in_ch.c_mode <= '0; in_ch.c_value <= '0; in_ch.d_mode <= '0; in_ch.d_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    v.check_typed = 1;
    v.instr = make_instr(F_LOAD, 16'd0, MODE_REG, 32'd9, MODE_IMM, 0);
    v.typed = make_outcome(1'b1, 32'd0, ERR_NONE); vectors.push_back(v);
    v.instr = make_instr(F_LOAD, 16'd9, MODE_IMM, 32'h8000_0000, MODE_IMM, 0);
    v.typed = make_outcome(1'b1, 32'h8000_0000, ERR_NONE); vectors.push_back(v);
    v.instr = make_instr(F_LOAD, 16'd1, MODE_IMM, 32'h7fff_ffff, MODE_IMM, 0);
    v.typed = make_outcome(1'b1, 32'h7fff_ffff, ERR_NONE); vectors.push_back(v);
    v.instr = make_instr(F_LOAD, 16'd10, MODE_IMM, 32'd5, MODE_IMM, 0);
    v.typed = make_outcome(1'b0, 32'd0, ERR_REG); vectors.push_back(v);
    v.instr = make_instr(F_LOAD, 16'hffff, MODE_IMM, 32'd5, MODE_IMM, 0);
    v.typed = make_outcome(1'b0, 32'd0, ERR_REG); vectors.push_back(v);
    v.instr = make_instr(F_STORE, 16'hffff, MODE_IMM, 32'hffff_ffff, MODE_IMM, 0);
    v.typed = make_outcome(1'b1, 32'hffff_ffff, ERR_NONE); vectors.push_back(v);
    v.instr = make_instr(F_LOAD, 16'd2, MODE_MEM, 32'h0001_0000, MODE_IMM, 0);
    v.typed = make_outcome(1'b0, 32'd0, ERR_ADDR); vectors.push_back(v);
    v.instr = make_instr(F_ADD, 16'd2, MODE_REG, 32'hffff_ffff, MODE_IMM, 0);
    v.typed = make_outcome(1'b0, 32'd0, ERR_REG); vectors.push_back(v);
    // zero divisor
    v.instr = make_instr(F_DIV, 16'd2, MODE_IMM, 32'd7, MODE_IMM, 0);
    v.typed = make_outcome(1'b0, 32'd0, ERR_DIV); vectors.push_back(v);
    // most negative over minus one wraps
    v.instr = make_instr(F_DIV, 16'd3, MODE_REG, 32'd9, MODE_IMM, 32'hffff_ffff);
    v.typed = make_outcome(1'b1, 32'h8000_0000, ERR_NONE); vectors.push_back(v);
    // zero to the power zero
    v.instr = make_instr(F_POW, 16'd4, MODE_IMM, 32'd0, MODE_IMM, 32'd0);
    v.typed = make_outcome(1'b1, 32'd1, ERR_NONE); vectors.push_back(v);
    // negative exponents
    v.instr = make_instr(F_POW, 16'd4, MODE_IMM, 32'hffff_ffff, MODE_IMM, 32'hffff_fffd);
    v.typed = make_outcome(1'b1, 32'hffff_ffff, ERR_NONE); vectors.push_back(v);
    v.instr = make_instr(F_POW, 16'd4, MODE_IMM, 32'd1, MODE_IMM, 32'h8000_0000);
    v.typed = make_outcome(1'b1, 32'd1, ERR_NONE); vectors.push_back(v);
    v.instr = make_instr(F_POW, 16'd4, MODE_IMM, 32'd2, MODE_IMM, 32'hffff_ffff);
    v.typed = make_outcome(1'b1, 32'd0, ERR_NONE); vectors.push_back(v);
    // no-op function code
    v.instr = make_instr(F_LOAD, 16'd0, MODE_IMM, 32'd1, MODE_IMM, 0);
    v.instr.func = 4'd15;
    v.typed = none; vectors.push_back(v);
    // guard never holds but its operands are checked
    v.instr = make_instr(F_LOAD, 16'd0, MODE_IMM, 32'd1, MODE_IMM, 0);
    v.instr.guard = G_NEVER;
    v.typed = none; vectors.push_back(v);
    v.instr.c_mode = MODE_MEM_ALT; v.instr.c_value = 32'h8000_0000;
    v.typed = make_outcome(1'b0, 32'd0, ERR_ADDR); vectors.push_back(v);
    v.instr.c_mode = MODE_IMM; v.instr.d_mode = MODE_REG; v.instr.d_value = 32'd10;
    v.typed = make_outcome(1'b0, 32'd0, ERR_REG); vectors.push_back(v);
    // predictor-checked rows: the remaining operations and guards
    v.check_typed = 0;
    v.instr = make_instr(F_SUB, 16'd5, MODE_REG, 32'd9, MODE_REG, 32'd1); vectors.push_back(v);
    v.instr = make_instr(F_MUL, 16'd6, MODE_REG, 32'd1, MODE_MEM_ALT, 32'hffff);
    vectors.push_back(v);
    v.instr = make_instr(F_AND, 16'd7, MODE_REG, 32'd1, MODE_IMM, 32'h0f0f_0f0f);
    vectors.push_back(v);
    v.instr = make_instr(F_OR, 16'd7, MODE_REG, 32'd7, MODE_IMM, 32'h8000_0001);
    vectors.push_back(v);
    v.instr = make_instr(F_XOR, 16'd8, MODE_REG, 32'd7, MODE_REG, 32'd9); vectors.push_back(v);
    v.instr = make_instr(F_NOT, 16'd8, MODE_REG, 32'd8, MODE_IMM, 0); vectors.push_back(v);
    for (int g = G_EQ; g <= G_GE; g++) begin
      v.instr = make_instr(F_ADD, 16'd2, MODE_REG, 32'd2, MODE_IMM, 32'd1);
      v.instr.guard = 3'(g);
      v.instr.c_mode = MODE_REG; v.instr.c_value = 32'd9;
      v.instr.d_mode = MODE_IMM; v.instr.d_value = (g % 2) ? 32'h8000_0000 : 32'd0;
      vectors.push_back(v);
    end
    foreach (vectors[i]) send_beat(vectors[i].instr, vectors[i].check_typed, vectors[i].typed);

    // hold off until every result is in
    wait_drained();

    // random phases with different idling
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        3: begin send_idle_pct = 23; recv_stall_pct = 23; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (370) begin
        it = random_instr();
        send_beat(it, 0, none);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d instructions, %0d results: %0d executed, %0d flagged errors",
             beats_sent, beats_seen, executed_seen, error_seen);
    $display("covered all functions, guards, operand modes and four idling mixes");
    if (mismatch_count == 0 && pending_outcomes.size() == 0)
      $display("register_machine_execute_unit_top_tb: done, clean");
    else
      $display("register_machine_execute_unit_top_tb: done, errors");
    $finish;
  end

endmodule
